/* hw/rtl/session_line_record_parser_macros.svh */
// ----------------------------------------------------------------------------
// session_line_record_parser_macros.svh
// Assertion helpers shared by the line record parser RTL.
// ----------------------------------------------------------------------------
`ifndef SESSION_LINE_RECORD_PARSER_MACROS_SVH
`define SESSION_LINE_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/slrp_pkg.sv */
// ----------------------------------------------------------------------------
// slrp_pkg
// Types, codes and character helpers of the session line record parser.
// ----------------------------------------------------------------------------
package slrp_pkg;

    typedef logic [7:0] t_byte;

    localparam int TL_W = 9;   // width of text_length

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_MISSING  = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    // Role codes
    localparam logic [1:0] ROLE_USER   = 2'd0;
    localparam logic [1:0] ROLE_AGENT  = 2'd1;
    localparam logic [1:0] ROLE_SYSTEM = 2'd2;

    // Value destinations
    typedef enum logic [1:0] {
        TGT_IGNORE = 2'd0,
        TGT_ROLE   = 2'd1,
        TGT_TEXT   = 2'd2
    } t_target;

    // Parser phase
    typedef enum logic [3:0] {
        PH_OPEN         = 4'd0,
        PH_KEY_OR_CLOSE = 4'd1,
        PH_KEY          = 4'd2,
        PH_COLON        = 4'd3,
        PH_VALUE_START  = 4'd4,
        PH_VALUE        = 4'd5,
        PH_SEP          = 4'd6,
        PH_DONE         = 4'd7,
        PH_ERROR        = 4'd8
    } t_phase;

    // Control sequencer
    typedef enum logic [1:0] {
        SQ_RUN   = 2'd0,
        SQ_READ  = 2'd1,
        SQ_CHUNK = 2'd2,
        SQ_STAT  = 2'd3
    } t_seq;

    // Structural characters
    localparam t_byte CH_LBRACE = 8'h7B;
    localparam t_byte CH_RBRACE = 8'h7D;
    localparam t_byte CH_COLON  = 8'h3A;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_BSLASH = 8'h5C;

    // Matched words
    localparam t_byte WORD_ROLE  [4] = '{8'h72, 8'h6F, 8'h6C, 8'h65};
    localparam t_byte WORD_TEXT  [4] = '{8'h74, 8'h65, 8'h78, 8'h74};
    localparam t_byte WORD_USER  [4] = '{8'h75, 8'h73, 8'h65, 8'h72};
    localparam t_byte WORD_AGENT [5] = '{8'h61, 8'h67, 8'h65, 8'h6E, 8'h74};

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_ws(input t_byte c);
        return (c inside {8'd32, [8'd9:8'd13]});
    endfunction

    // Escape decode: {known, decoded byte}
    function automatic logic [8:0] esc_decode(input t_byte c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h6E:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            default: r = {1'b0, 8'h00};
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/slrp_if.sv */
// ----------------------------------------------------------------------------
// slrp_if
// Valid/ready channels of the line record parser: characters in, results out.
// ----------------------------------------------------------------------------
interface slrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_line;

    modport source (output valid, output ch, output end_of_line, input ready);
    modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface slrp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] chunk;
    logic [3:0]  chunk_bytes;
    logic [1:0]  status;
    logic [1:0]  role;
    logic [8:0]  text_length;
    logic        last;

    modport source (output valid, output kind, output chunk, output chunk_bytes,
                    output status, output role, output text_length, output last,
                    input ready);
    modport sink   (input valid, input kind, input chunk, input chunk_bytes,
                    input status, input role, input text_length, input last,
                    output ready);
endinterface

/* hw/rtl/session_line_record_parser.sv */
// ----------------------------------------------------------------------------
// session_line_record_parser
// Parses one line of a flat string object, keeps the decoded text in a
// row-organized byte store and replays it in 8-byte chunks at end of line.
//
// i_in carries one request per character, then one end-of-line request.
// Characters are taken at one per cycle while not draining; they produce no result.
// After an end-of-line request the input stalls while o_out gives the text
// chunks (only when the status is ok) followed by one status request with
// last set. Each chunk takes a store read (SQ_READ) followed by an output
// step (SQ_CHUNK). The status comes in the cycle after the end of line or
// in the cycle after the last chunk is taken.
// The store has one byte-write port and one 64-bit row read port; writes
// happen only while characters arrive, reads only while draining.
// A stall on o_out holds the current result; nothing advances until taken.
// After reset the parser waits for an opening brace; the store holds no
// valid data and needs no clearing.
// ----------------------------------------------------------------------------
`include "session_line_record_parser_macros.svh"

module session_line_record_parser
    import slrp_pkg::*;
#(
    parameter int TEXT_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slrp_in_if.sink     i_in,
    slrp_out_if.source  o_out
);

    localparam int ROWS  = TEXT_DEPTH / 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(TEXT_DEPTH + 1);

    // Sequencer
    t_seq r_state, n_state;

    // Parser state
    t_phase            r_phase, n_phase;
    logic              r_esc, n_esc;
    logic [2:0]        r_key_pos, n_key_pos;
    logic [1:0]        r_key_cand, n_key_cand;
    t_target           r_target, n_target;
    logic [2:0]        r_role_pos, n_role_pos;
    logic [1:0]        r_role_cand, n_role_cand;
    logic [1:0]        r_role_code, n_role_code;
    logic              r_have_text, n_have_text;
    logic [CNT_W-1:0]  r_text_count, n_text_count;
    logic              r_overflow, n_overflow;

    // Drain state
    t_status           r_status, n_status;
    logic [CNT_W-1:0]  r_pos, n_pos;

    // Store
    logic [63:0]       r_mem [0:ROWS-1];
    logic [63:0]       r_rdata;
    logic              w_we;
    logic [ROW_W-1:0]  w_wrow;
    logic [2:0]        w_lane;
    t_byte             w_wbyte;
    logic              w_rd;

    // Handshake helpers
    logic              w_in_fire;
    logic              w_out_fire;
    logic              w_eol;
    t_byte             w_c;
    t_status           w_line_status;
    logic [CNT_W-1:0]  w_rem;
    logic [3:0]        w_cnt;
    logic [63:0]       w_chunk;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_eol      = i_in.end_of_line;
    assign w_c        = i_in.ch;

    // Status of the line as it stands
    always_comb begin
        if (r_phase != PH_DONE) begin
            w_line_status = ST_SYNTAX;
        end else if (!r_have_text) begin
            w_line_status = ST_MISSING;
        end else if (r_overflow) begin
            w_line_status = ST_TOO_LONG;
        end else begin
            w_line_status = ST_OK;
        end
    end

    // Bytes left to drain and this chunk's byte count
    assign w_rem = r_text_count - r_pos;
    assign w_cnt = (w_rem > CNT_W'(8)) ? 4'd8 : w_rem[3:0];

    // Mask off bytes past the end of the text
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_chunk[8*k +: 8] = (4'(k) < w_cnt) ? r_rdata[8*k +: 8] : 8'h00;
        end
    end

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_RUN: begin
                if (w_in_fire && w_eol) begin
                    if (w_line_status == ST_OK && r_text_count != '0) begin
                        n_state = SQ_READ;
                    end else begin
                        n_state = SQ_STAT;
                    end
                end
            end
            SQ_READ: begin
                n_state = SQ_CHUNK;
            end
            SQ_CHUNK: begin
                if (o_out.ready) begin
                    n_state = (w_rem > CNT_W'(8)) ? SQ_READ : SQ_STAT;
                end
            end
            SQ_STAT: begin
                if (o_out.ready) begin
                    n_state = SQ_RUN;
                end
            end
            default: n_state = SQ_RUN;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_in.ready        = (r_state == SQ_RUN);
        o_out.valid       = (r_state == SQ_CHUNK) || (r_state == SQ_STAT);
        w_rd              = (r_state == SQ_READ);
        o_out.kind        = (r_state == SQ_STAT);
        o_out.last        = (r_state == SQ_STAT);
        o_out.chunk       = (r_state == SQ_CHUNK) ? w_chunk : 64'd0;
        o_out.chunk_bytes = (r_state == SQ_CHUNK) ? w_cnt : 4'd0;
        o_out.status      = (r_state == SQ_STAT) ? r_status : ST_OK;
        if (r_status == ST_OK) begin
            o_out.role        = r_role_code;
            o_out.text_length = TL_W'(r_text_count);
        end else begin
            o_out.role        = ROLE_SYSTEM;
            o_out.text_length = '0;
        end
    end

    // Character parser and drain bookkeeping
    always_comb begin
        logic [8:0] esc;
        logic       take;
        t_byte      b;

        n_phase      = r_phase;
        n_esc        = r_esc;
        n_key_pos    = r_key_pos;
        n_key_cand   = r_key_cand;
        n_target     = r_target;
        n_role_pos   = r_role_pos;
        n_role_cand  = r_role_cand;
        n_role_code  = r_role_code;
        n_have_text  = r_have_text;
        n_text_count = r_text_count;
        n_overflow   = r_overflow;
        n_status     = r_status;
        n_pos        = r_pos;
        w_we         = 1'b0;
        w_wrow       = r_text_count[ROW_W+2:3];
        w_lane       = r_text_count[2:0];
        w_wbyte      = 8'h00;
        esc          = esc_decode(w_c);
        take         = 1'b0;
        b            = w_c;

        if (w_in_fire && !w_eol) begin
            case (r_phase)
                PH_OPEN: begin
                    if (w_c == CH_LBRACE) begin
                        n_phase = PH_KEY_OR_CLOSE;
                    end else if (!is_ws(w_c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_KEY_OR_CLOSE: begin
                    if (w_c == CH_RBRACE) begin
                        n_phase = PH_DONE;
                    end else if (w_c == CH_QUOTE) begin
                        n_phase    = PH_KEY;
                        n_key_pos  = 3'd0;
                        n_key_cand = 2'b11;
                        n_esc      = 1'b0;
                    end else if (!is_ws(w_c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_COLON: begin
                    if (w_c == CH_COLON) begin
                        n_phase = PH_VALUE_START;
                    end else if (!is_ws(w_c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_VALUE_START: begin
                    if (w_c == CH_QUOTE) begin
                        n_phase = PH_VALUE;
                        n_esc   = 1'b0;
                        if (r_target == TGT_ROLE) begin
                            n_role_pos  = 3'd0;
                            n_role_cand = 2'b11;
                        end else if (r_target == TGT_TEXT) begin
                            n_text_count = '0;
                            n_overflow   = 1'b0;
                        end
                    end else if (!is_ws(w_c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_KEY, PH_VALUE: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (esc[8]) begin
                            take = 1'b1;
                            b    = esc[7:0];
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end else if (w_c == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (w_c == CH_QUOTE) begin
                        // Closing quote
                        if (r_phase == PH_KEY) begin
                            if (r_key_pos == 3'd4 && r_key_cand[0]) begin
                                n_target = TGT_ROLE;
                            end else if (r_key_pos == 3'd4 && r_key_cand[1]) begin
                                n_target = TGT_TEXT;
                            end else begin
                                n_target = TGT_IGNORE;
                            end
                            n_phase = PH_COLON;
                        end else begin
                            if (r_target == TGT_ROLE) begin
                                if (r_role_pos == 3'd4 && r_role_cand[0]) begin
                                    n_role_code = ROLE_USER;
                                end else if (r_role_pos == 3'd5 && r_role_cand[1]) begin
                                    n_role_code = ROLE_AGENT;
                                end else begin
                                    n_role_code = ROLE_SYSTEM;
                                end
                            end else if (r_target == TGT_TEXT) begin
                                n_have_text = 1'b1;
                            end
                            n_phase = PH_SEP;
                        end
                    end else begin
                        take = 1'b1;
                    end
                end
                PH_SEP: begin
                    if (w_c == CH_COMMA) begin
                        n_phase = PH_KEY_OR_CLOSE;
                    end else if (w_c == CH_RBRACE) begin
                        n_phase = PH_DONE;
                    end else if (!is_ws(w_c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_DONE: begin
                    if (!is_ws(w_c)) begin
                        n_phase = PH_ERROR;
                    end
                end
                default: ;
            endcase

            // One string byte: key match, role match or text store
            if (take) begin
                if (r_phase == PH_KEY) begin
                    if (r_key_pos < 3'd4) begin
                        if (b != WORD_ROLE[r_key_pos[1:0]]) n_key_cand[0] = 1'b0;
                        if (b != WORD_TEXT[r_key_pos[1:0]]) n_key_cand[1] = 1'b0;
                        n_key_pos = r_key_pos + 3'd1;
                    end else begin
                        n_key_cand = 2'b00;
                    end
                end else if (r_target == TGT_ROLE) begin
                    if (r_role_pos < 3'd5) begin
                        if (r_role_pos >= 3'd4 || b != WORD_USER[r_role_pos[1:0]]) begin
                            n_role_cand[0] = 1'b0;
                        end
                        if (b != WORD_AGENT[r_role_pos]) n_role_cand[1] = 1'b0;
                        n_role_pos = r_role_pos + 3'd1;
                    end else begin
                        n_role_cand = 2'b00;
                    end
                end else if (r_target == TGT_TEXT) begin
                    if (r_text_count < CNT_W'(TEXT_DEPTH)) begin
                        w_we         = 1'b1;
                        w_wbyte      = b;
                        n_text_count = r_text_count + CNT_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                end
            end
        end

        // End of line: latch status, start the drain
        if (w_in_fire && w_eol) begin
            n_status = w_line_status;
            n_pos    = '0;
        end

        if (r_state == SQ_CHUNK && o_out.ready) begin
            n_pos = r_pos + CNT_W'(8);
        end

        // Status taken: fresh line
        if (r_state == SQ_STAT && o_out.ready) begin
            n_phase      = PH_OPEN;
            n_esc        = 1'b0;
            n_key_pos    = 3'd0;
            n_key_cand   = 2'b11;
            n_target     = TGT_IGNORE;
            n_role_pos   = 3'd0;
            n_role_cand  = 2'b11;
            n_role_code  = ROLE_SYSTEM;
            n_have_text  = 1'b0;
            n_text_count = '0;
            n_overflow   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= SQ_RUN;
            r_phase      <= PH_OPEN;
            r_esc        <= 1'b0;
            r_key_pos    <= 3'd0;
            r_key_cand   <= 2'b11;
            r_target     <= TGT_IGNORE;
            r_role_pos   <= 3'd0;
            r_role_cand  <= 2'b11;
            r_role_code  <= ROLE_SYSTEM;
            r_have_text  <= 1'b0;
            r_text_count <= '0;
            r_overflow   <= 1'b0;
            r_status     <= ST_OK;
            r_pos        <= '0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_esc        <= n_esc;
            r_key_pos    <= n_key_pos;
            r_key_cand   <= n_key_cand;
            r_target     <= n_target;
            r_role_pos   <= n_role_pos;
            r_role_cand  <= n_role_cand;
            r_role_code  <= n_role_code;
            r_have_text  <= n_have_text;
            r_text_count <= n_text_count;
            r_overflow   <= n_overflow;
            r_status     <= n_status;
            r_pos        <= n_pos;
        end
    end

    // Text store: byte write, registered row read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wrow][{w_lane, 3'b000} +: 8] <= w_wbyte;
        end
        if (w_rd) begin
            r_rdata <= r_mem[r_pos[ROW_W+2:3]];
        end
    end

    // Checks
    `SLRP_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1,
        r_text_count <= CNT_W'(TEXT_DEPTH), "text count beyond store depth")
    `SLRP_ASSERT_NOW(a_chunk_bytes, i_clk, i_rst_n, o_out.valid && !o_out.kind,
        o_out.chunk_bytes != 4'd0 && o_out.chunk_bytes <= 4'd8, "bad chunk byte count")
    `SLRP_ASSERT_NOW(a_chunk_only_ok, i_clk, i_rst_n, r_state == SQ_CHUNK,
        r_status == ST_OK, "chunk emitted for a failed line")
    `SLRP_ASSERT_NEXT(a_eol_drains, i_clk, i_rst_n, w_in_fire && w_eol,
        r_state == SQ_READ || r_state == SQ_STAT, "end of line did not start drain")
    `SLRP_ASSERT_NEXT(a_status_clears, i_clk, i_rst_n, w_out_fire && o_out.kind,
        r_state == SQ_RUN && r_phase == PH_OPEN && r_text_count == '0,
        "line state not cleared after status")

endmodule
